>>> rtl/smi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smi_pkg
// Widths and types shared by the small matrix inverse pipeline and checker.
// ----------------------------------------------------------------------------
package smi_pkg;

  localparam int DW    = 32;             // element width
  localparam int FB    = 16;             // fraction bits
  localparam int NEL   = 9;              // element slots
  localparam int PRW   = 2 * DW;         // element product width
  localparam int PW    = 2 * DW + 2;     // cofactor width
  localparam int DETW  = 3 * DW + 4;     // determinant width
  localparam int NUMW  = PW + 2 * FB;    // shifted numerator width
  localparam int RW    = ((NUMW > DETW + DW) ? NUMW : DETW + DW) + 1;
  localparam int QW    = DW - 1;         // quotient bits below saturation
  localparam int NSTEP = DW - 1;         // one quotient bit per stage

  typedef logic signed [DW-1:0]   data_t;
  typedef logic signed [PRW-1:0]  prod_t;
  typedef logic signed [PW-1:0]   cof_t;
  typedef logic signed [DETW-1:0] det_t;
  typedef logic [RW-1:0]          rem_t;
  typedef logic [QW-1:0]          quo_t;

  localparam data_t DATA_MAX = {1'b0, {(DW-1){1'b1}}};
  localparam data_t DATA_MIN = {1'b1, {(DW-1){1'b0}}};

  localparam logic [1:0] SIZE_ONE   = 2'd1;
  localparam logic [1:0] SIZE_TWO   = 2'd2;
  localparam logic [1:0] SIZE_THREE = 2'd3;

endpackage

>>> rtl/small_matrix_inverse_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// small_matrix_inverse_top
// Pipelined adjugate inverse of a 1x1, 2x2 or 3x3 signed fixed-point matrix.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o) moves one item: the size and nine
//   row-major elements a00..a22. Slots beyond the size are ignored.
//   Output channel (out_valid_o / out_ready_i) moves one item: the singular
//   flag and the inverse b00..b22, saturated; unused slots read zero, and a
//   singular (or size zero) matrix gives singular = 1 with all outputs zero.
//   The pipeline holds two stages of cofactor products, two of determinant
//   partial products and sum, one of sign and saturation test, one restoring
//   divider stage per quotient bit (nine dividers side by side), and the
//   output register. Throughput is one item per cycle while the output
//   register is empty or being taken; every stage holds its own valid bit.
//   All stages advance together whenever the output register is empty or
//   being taken, so a stall on the receiver freezes the whole pipeline and
//   drops in_ready_o in the same cycle; nothing is lost or repeated.
//   Reset clears all valid bits; no state survives between items.
// ----------------------------------------------------------------------------
module small_matrix_inverse_top
  import smi_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [1:0]    size_i,
  input  data_t         a00_i,
  input  data_t         a01_i,
  input  data_t         a02_i,
  input  data_t         a10_i,
  input  data_t         a11_i,
  input  data_t         a12_i,
  input  data_t         a20_i,
  input  data_t         a21_i,
  input  data_t         a22_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic          singular_o,
  output data_t         b00_o,
  output data_t         b01_o,
  output data_t         b02_o,
  output data_t         b10_o,
  output data_t         b11_o,
  output data_t         b12_o,
  output data_t         b20_o,
  output data_t         b21_o,
  output data_t         b22_o
);

  // Global advance: the whole pipe moves when the output slot frees up.
  logic adv;
  logic out_v_q;
  assign adv        = !out_v_q || out_ready_i;
  assign in_ready_o = adv;

  data_t a_in [NEL];
  assign a_in = '{a00_i, a01_i, a02_i, a10_i, a11_i, a12_i, a20_i, a21_i, a22_i};

  // --------------------------------------------------------------------------
  // Stage 1: the two minor products of every cofactor.
  // Cofactor (i,j) = a[i1][j1]*a[i2][j2] - a[i1][j2]*a[i2][j1], indices mod 3.
  // --------------------------------------------------------------------------
  logic        v1_q;
  logic [1:0]  size1_q;
  data_t       a1_q  [NEL];
  prod_t       p0_1_q[NEL];
  prod_t       p1_1_q[NEL];
  prod_t       p0_1_d[NEL];
  prod_t       p1_1_d[NEL];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        p0_1_d[3*i+j] = a_in[3*((i+1)%3)+((j+1)%3)] * a_in[3*((i+2)%3)+((j+2)%3)];
        p1_1_d[3*i+j] = a_in[3*((i+1)%3)+((j+2)%3)] * a_in[3*((i+2)%3)+((j+1)%3)];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: cofactors, adjugate by size, and the small-size determinants.
  // --------------------------------------------------------------------------
  logic        v2_q;
  logic [1:0]  size2_q;
  cof_t        adj2_q [NEL];
  cof_t        adj2_d [NEL];
  data_t       row2_q [3];
  cof_t        col2_q [3];
  det_t        dpre2_q;
  det_t        dpre2_d;
  cof_t        cof    [NEL];

  always_comb begin
    for (int k = 0; k < NEL; k++) begin
      cof[k]    = cof_t'(p0_1_q[k]) - cof_t'(p1_1_q[k]);
      adj2_d[k] = '0;
    end
    dpre2_d = '0;
    unique case (size1_q)
      SIZE_ONE: begin
        adj2_d[0] = cof_t'(1);
        dpre2_d   = det_t'(a1_q[0]);
      end
      SIZE_TWO: begin
        adj2_d[0] = cof_t'(a1_q[4]);
        adj2_d[1] = -cof_t'(a1_q[1]);
        adj2_d[3] = -cof_t'(a1_q[3]);
        adj2_d[4] = cof_t'(a1_q[0]);
        dpre2_d   = det_t'(cof[8]);   // minor of the lower-right slot
      end
      SIZE_THREE: begin
        // transpose: cofactor (i,j) lands in adjugate slot (j,i)
        for (int i = 0; i < 3; i++) begin
          for (int j = 0; j < 3; j++) begin
            adj2_d[3*j+i] = cof[3*i+j];
          end
        end
      end
      default: begin
        dpre2_d = '0;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Stage 3: determinant partial products, cofactor split into low and high.
  // --------------------------------------------------------------------------
  localparam int LOW = 2 * DW + 1;
  localparam int HIW = 2 * DW + 2;

  logic                  v3_q;
  logic [1:0]            size3_q;
  cof_t                  adj3_q [NEL];
  det_t                  dpre3_q;
  logic signed [LOW-1:0] lo3_q  [3];
  logic signed [HIW-1:0] hi3_q  [3];
  logic signed [LOW-1:0] lo3_d  [3];
  logic signed [HIW-1:0] hi3_d  [3];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      lo3_d[j] = row2_q[j] * $signed({1'b0, col2_q[j][DW-1:0]});
      hi3_d[j] = row2_q[j] * $signed(col2_q[j][PW-1:DW]);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: determinant sum and singular test.
  // --------------------------------------------------------------------------
  logic        v4_q;
  logic        sing4_q;
  cof_t        adj4_q [NEL];
  det_t        det4_q;
  det_t        det3;
  det_t        det4_d;

  always_comb begin
    det3 = '0;
    for (int j = 0; j < 3; j++) begin
      det3 = det3 + (det_t'(hi3_q[j]) <<< DW) + det_t'(lo3_q[j]);
    end
    det4_d = (size3_q == SIZE_THREE) ? det3 : dpre3_q;
  end

  // --------------------------------------------------------------------------
  // Stage 5: magnitudes, result sign, and saturation test
  // (quotient reaches 2^(DW-1) exactly when n >= d * 2^(DW-1)).
  // --------------------------------------------------------------------------
  logic [DETW-1:0] dabs;
  rem_t            num   [NEL];
  logic [PW-1:0]   aabs  [NEL];

  always_comb begin
    dabs = det4_q[DETW-1] ? DETW'(-det4_q) : DETW'(det4_q);
    for (int k = 0; k < NEL; k++) begin
      aabs[k] = adj4_q[k][PW-1] ? PW'(-adj4_q[k]) : PW'(adj4_q[k]);
      num[k]  = RW'(aabs[k]) << (2 * FB);
    end
  end

  // Divider pipe: index 0 is the stage 5 register, index s+1 follows step s.
  logic            dv_q   [NSTEP+1];
  logic            dsing_q[NSTEP+1];
  logic [DETW-1:0] dd_q   [NSTEP+1];
  rem_t            dr_q   [NSTEP+1][NEL];
  quo_t            dq_q   [NSTEP+1][NEL];
  logic            dsat_q [NSTEP+1][NEL];
  logic            dneg_q [NSTEP+1][NEL];

  rem_t            dr_d   [NSTEP][NEL];
  quo_t            dq_d   [NSTEP][NEL];
  rem_t            dsh    [NSTEP];

  // Restoring step: quotient bit NSTEP-1-s decided in step s.
  always_comb begin
    for (int s = 0; s < NSTEP; s++) begin
      dsh[s] = RW'(dd_q[s]) << (NSTEP - 1 - s);
      for (int k = 0; k < NEL; k++) begin
        if (dr_q[s][k] >= dsh[s]) begin
          dr_d[s][k] = dr_q[s][k] - dsh[s];
          dq_d[s][k] = dq_q[s][k] | (quo_t'(1) << (NSTEP - 1 - s));
        end else begin
          dr_d[s][k] = dr_q[s][k];
          dq_d[s][k] = dq_q[s][k];
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output stage: sign, saturation and singular override.
  // --------------------------------------------------------------------------
  logic  sing_q;
  data_t b_q [NEL];
  data_t b_d [NEL];

  always_comb begin
    for (int k = 0; k < NEL; k++) begin
      if (dsing_q[NSTEP]) begin
        b_d[k] = '0;
      end else if (dsat_q[NSTEP][k]) begin
        b_d[k] = dneg_q[NSTEP][k] ? DATA_MIN : DATA_MAX;
      end else if (dneg_q[NSTEP][k]) begin
        b_d[k] = -data_t'({1'b0, dq_q[NSTEP][k]});
      end else begin
        b_d[k] = data_t'({1'b0, dq_q[NSTEP][k]});
      end
    end
  end

  // Valid bits: reset clears them, advance moves them.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      v4_q    <= 1'b0;
      out_v_q <= 1'b0;
      for (int s = 0; s <= NSTEP; s++) begin
        dv_q[s] <= 1'b0;
      end
    end else if (adv) begin
      v1_q    <= in_valid_i;
      v2_q    <= v1_q;
      v3_q    <= v2_q;
      v4_q    <= v3_q;
      dv_q[0] <= v4_q;
      for (int s = 0; s < NSTEP; s++) begin
        dv_q[s+1] <= dv_q[s];
      end
      out_v_q <= dv_q[NSTEP];
    end
  end

  // Payload: no reset, hold on stall.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      size1_q <= size_i;
      for (int k = 0; k < NEL; k++) begin
        a1_q[k]   <= a_in[k];
        p0_1_q[k] <= p0_1_d[k];
        p1_1_q[k] <= p1_1_d[k];
      end

      size2_q <= size1_q;
      dpre2_q <= dpre2_d;
      for (int k = 0; k < NEL; k++) begin
        adj2_q[k] <= adj2_d[k];
      end
      for (int j = 0; j < 3; j++) begin
        row2_q[j] <= a1_q[j];
        col2_q[j] <= cof[j];
      end

      size3_q <= size2_q;
      dpre3_q <= dpre2_q;
      for (int k = 0; k < NEL; k++) begin
        adj3_q[k] <= adj2_q[k];
      end
      for (int j = 0; j < 3; j++) begin
        lo3_q[j] <= lo3_d[j];
        hi3_q[j] <= hi3_d[j];
      end

      sing4_q <= (det4_d == '0) || (size3_q == 2'd0);
      det4_q  <= det4_d;
      for (int k = 0; k < NEL; k++) begin
        adj4_q[k] <= adj3_q[k];
      end

      dsing_q[0] <= sing4_q;
      dd_q[0]    <= dabs;
      for (int k = 0; k < NEL; k++) begin
        dr_q[0][k]   <= num[k];
        dq_q[0][k]   <= '0;
        dsat_q[0][k] <= num[k] >= (RW'(dabs) << (DW - 1));
        dneg_q[0][k] <= adj4_q[k][PW-1] ^ det4_q[DETW-1];
      end

      for (int s = 0; s < NSTEP; s++) begin
        dsing_q[s+1] <= dsing_q[s];
        dd_q[s+1]    <= dd_q[s];
        for (int k = 0; k < NEL; k++) begin
          dr_q[s+1][k]   <= dr_d[s][k];
          dq_q[s+1][k]   <= dq_d[s][k];
          dsat_q[s+1][k] <= dsat_q[s][k];
          dneg_q[s+1][k] <= dneg_q[s][k];
        end
      end

      sing_q <= dsing_q[NSTEP];
      for (int k = 0; k < NEL; k++) begin
        b_q[k] <= b_d[k];
      end
    end
  end

  assign out_valid_o = out_v_q;
  assign singular_o  = sing_q;
  assign b00_o = b_q[0];
  assign b01_o = b_q[1];
  assign b02_o = b_q[2];
  assign b10_o = b_q[3];
  assign b11_o = b_q[4];
  assign b12_o = b_q[5];
  assign b20_o = b_q[6];
  assign b21_o = b_q[7];
  assign b22_o = b_q[8];

endmodule

>>> rtl/smi_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smi_checker
// Port-level assertions for the small matrix inverse, bound to the top level.
// ----------------------------------------------------------------------------
module smi_checker
  import smi_pkg::*;
(
  input logic  clk_i,
  input logic  rst_ni,
  input logic  in_ready_o,
  input logic  out_valid_o,
  input logic  out_ready_i,
  input logic  singular_o,
  input data_t b00_o,
  input data_t b11_o,
  input data_t b22_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output item dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(b00_o) && $stable(singular_o))
    else $error("stalled output item changed");

  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == (!out_valid_o || out_ready_i))
    else $error("input ready does not follow output slot");

  a_sing_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && singular_o |-> b00_o == '0 && b11_o == '0 && b22_o == '0)
    else $error("singular item carries nonzero elements");

endmodule

bind small_matrix_inverse_top smi_checker u_smi_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .singular_o  (singular_o),
  .b00_o       (b00_o),
  .b11_o       (b11_o),
  .b22_o       (b22_o)
);

>>> tb/small_matrix_inverse_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// small_matrix_inverse_checker
// Watches both channels of the inverse pipeline, computes each inverse in
// wide exact arithmetic and compares it field by field with what comes out.
// ----------------------------------------------------------------------------
module small_matrix_inverse_checker
  import smi_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_ready_i,
  input  logic [1:0]       size_i,
  input  logic [9*DW-1:0]  mat_i,
  input  logic             out_valid_i,
  input  logic             out_ready_i,
  input  logic             singular_i,
  input  logic [9*DW-1:0]  inv_i,
  output int               fail_count_o,
  output int               pending_o,
  output int               inv_count_o,
  output int               singular_count_o
);

  typedef logic signed [255:0] wide_t;

  typedef struct {
    logic  singular;
    data_t b [9];
  } inverse_t;

  inverse_t inverse_q [$];

  // Saturated Q-format quotient of one adjugate entry over the determinant.
  function automatic data_t adj_quotient(wide_t adj, wide_t det);
    wide_t q;
    wide_t hi;
    wide_t lo;
    begin
      hi = DATA_MAX;
      lo = DATA_MIN;
      q  = (adj <<< (2 * FB)) / det;
      if (q > hi) q = hi;
      if (q < lo) q = lo;
      return q[DW-1:0];
    end
  endfunction

  function automatic inverse_t compute_inverse(logic [1:0] n, logic [9*DW-1:0] flat);
    wide_t    m [3][3];
    wide_t    adj [3][3];
    wide_t    det;
    inverse_t r;
    int       i1, i2, j1, j2;
    begin
      r.singular = 1'b0;
      for (int k = 0; k < 9; k++) r.b[k] = '0;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          m[i][j]   = data_t'(flat[DW*(8-(3*i+j)) +: DW]);
          adj[i][j] = '0;
        end
      end
      det = '0;
      case (n)
        SIZE_ONE: begin
          adj[0][0] = 1;
          det       = m[0][0];
        end
        SIZE_TWO: begin
          adj[0][0] = m[1][1];
          adj[0][1] = -m[0][1];
          adj[1][0] = -m[1][0];
          adj[1][1] = m[0][0];
          det       = m[0][0] * m[1][1] - m[0][1] * m[1][0];
        end
        SIZE_THREE: begin
          for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
              i1 = (i + 1) % 3; i2 = (i + 2) % 3;
              j1 = (j + 1) % 3; j2 = (j + 2) % 3;
              // cofactor (i,j) lands transposed in the adjugate
              adj[j][i] = m[i1][j1] * m[i2][j2] - m[i1][j2] * m[i2][j1];
            end
          end
          for (int j = 0; j < 3; j++) det = det + m[0][j] * adj[j][0];
        end
        default: det = '0;
      endcase
      if (det == 0) begin
        r.singular = 1'b1;
      end else begin
        for (int i = 0; i < n; i++)
          for (int j = 0; j < n; j++)
            r.b[3*i+j] = adj_quotient(adj[i][j], det);
      end
      return r;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    inverse_t exp_inv;
    data_t    got;
    int       errs;
    if (!rst_ni) begin
      inverse_q.delete();
      fail_count_o     <= 0;
      inv_count_o      <= 0;
      singular_count_o <= 0;
    end else begin
      errs = 0;
      if (in_valid_i && in_ready_i) inverse_q.push_back(compute_inverse(size_i, mat_i));
      if (out_valid_i && out_ready_i) begin
        inv_count_o <= inv_count_o + 1;
        if (inverse_q.size() == 0) begin
          $error("inverse item with nothing pending");
          errs++;
        end else begin
          exp_inv = inverse_q.pop_front();
          if (exp_inv.singular) singular_count_o <= singular_count_o + 1;
          if (singular_i !== exp_inv.singular) begin
            $error("singular: expected %0b, got %0b", exp_inv.singular, singular_i);
            errs++;
          end
          for (int k = 0; k < 9; k++) begin
            got = inv_i[DW*(8-k) +: DW];
            if (got !== exp_inv.b[k]) begin
              $error("b%0d%0d: expected %0d, got %0d", k / 3, k % 3, exp_inv.b[k], got);
              errs++;
            end
          end
        end
      end
      if (errs != 0) fail_count_o <= fail_count_o + errs;
    end
  end

  assign pending_o = inverse_q.size();

endmodule

>>> tb/tb_small_matrix_inverse_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_small_matrix_inverse_top
// Drives directed and random matrices of size 0 to 3 into the inverse
// pipeline under varying back-pressure; the checker does all comparing.
// ----------------------------------------------------------------------------
module tb_small_matrix_inverse_top;
  import smi_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 60;    // settling wait after the last drain
  localparam int N_RANDOM    = 1000;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [1:0] size_i;
  data_t      a_i [9];
  logic       out_valid_o;
  logic       out_ready_i;
  logic       singular_o;
  data_t      b_o [9];

  int fail_count, pending, inv_count, singular_count;
  int tx_idle_pct, rx_idle_pct;
  int cycles;
  int size_seen [4];

  small_matrix_inverse_top dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .size_i,
    .a00_i(a_i[0]), .a01_i(a_i[1]), .a02_i(a_i[2]),
    .a10_i(a_i[3]), .a11_i(a_i[4]), .a12_i(a_i[5]),
    .a20_i(a_i[6]), .a21_i(a_i[7]), .a22_i(a_i[8]),
    .out_valid_o, .out_ready_i, .singular_o,
    .b00_o(b_o[0]), .b01_o(b_o[1]), .b02_o(b_o[2]),
    .b10_o(b_o[3]), .b11_o(b_o[4]), .b12_o(b_o[5]),
    .b20_o(b_o[6]), .b21_o(b_o[7]), .b22_o(b_o[8])
  );

  small_matrix_inverse_checker checker_i (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_i(in_ready_o), .size_i,
    .mat_i({a_i[0], a_i[1], a_i[2], a_i[3], a_i[4], a_i[5], a_i[6], a_i[7], a_i[8]}),
    .out_valid_i(out_valid_o), .out_ready_i, .singular_i(singular_o),
    .inv_i({b_o[0], b_o[1], b_o[2], b_o[3], b_o[4], b_o[5], b_o[6], b_o[7], b_o[8]}),
    .fail_count_o(fail_count), .pending_o(pending),
    .inv_count_o(inv_count), .singular_count_o(singular_count)
  );

  always begin
    clk_i = 1'b1; #5;
    clk_i = 1'b0; #5;
  end

  // Receiver: drop ready at random per the current idle rate.
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Watchdog: end the run if the pipeline wedges.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("small_matrix_inverse_top test failed");
      $finish;
    end
  end

  // Offer one item and hold it until taken; optionally idle first.
  task automatic send_matrix(logic [1:0] n, data_t m [9]);
    logic taken;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    size_i     <= n;
    for (int k = 0; k < 9; k++) a_i[k] <= m[k];
    size_seen[n]++;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = in_ready_o;
      @(posedge clk_i);
    end
  endtask

  // Hold the sender off until every pending inverse has drained.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  function automatic data_t rand_elem();
    case ($urandom_range(4))
      0: return data_t'($urandom);
      1: return data_t'($signed($urandom_range(0, 20'h7ffff)) - 20'sh40000);
      2: begin
        case ($urandom_range(5))
          0: return DATA_MAX;
          1: return DATA_MIN;
          2: return '0;
          3: return data_t'(1);
          4: return -data_t'(1);
          default: return data_t'(1 << FB);
        endcase
      end
      default: return data_t'(($signed($urandom_range(0, 8)) - 4) <<< FB);
    endcase
  endfunction

  // One random matrix; sometimes force a dependent row to hit singular.
  task automatic send_random();
    data_t      m [9];
    logic [1:0] n;
    n = ($urandom_range(49) == 0) ? 2'd0 : 2'($urandom_range(1, 3));
    for (int k = 0; k < 9; k++) m[k] = rand_elem();
    if ($urandom_range(9) == 0) begin
      for (int c = 0; c < 3; c++) m[3 + c] = m[c];
    end
    send_matrix(n, m);
  endtask

  task automatic send_fill(logic [1:0] n, data_t v);
    data_t m [9];
    for (int k = 0; k < 9; k++) m[k] = v;
    send_matrix(n, m);
  endtask

  localparam data_t ONE = data_t'(1 << FB);

  initial begin
    data_t m [9];
    cycles      = 0;
    tx_idle_pct = 36;
    rx_idle_pct = 80;
    in_valid_i  = 1'b0;
    out_ready_i = 1'b0;
    size_i      = SIZE_ONE;
    for (int k = 0; k < 9; k++) a_i[k] = '0;
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: scalars, identities, singular cases, extremes, size zero.
    send_fill(SIZE_ONE, ONE);
    send_fill(SIZE_ONE, '0);
    send_fill(SIZE_ONE, -ONE);
    send_fill(SIZE_ONE, data_t'(1));           // saturates high
    send_fill(SIZE_ONE, -data_t'(1));          // saturates low
    send_fill(SIZE_ONE, DATA_MAX);
    send_fill(SIZE_ONE, DATA_MIN);
    send_fill(SIZE_TWO, ONE);                  // all-equal rows: singular
    send_fill(SIZE_THREE, DATA_MIN);
    send_fill(SIZE_THREE, DATA_MAX);
    send_fill(2'd0, ONE);
    send_fill(SIZE_THREE, data_t'(32'h5555_5555));
    send_fill(SIZE_TWO, data_t'(32'haaaa_aaaa));
    for (int n = 1; n <= 3; n++) begin
      // identity, with junk in the unused slots
      for (int k = 0; k < 9; k++)
        m[k] = (k / 3 < n && k % 3 < n) ? ((k / 3 == k % 3) ? ONE : '0) : DATA_MIN;
      send_matrix(2'(n), m);
    end
    m = '{DATA_MAX, DATA_MIN, '0, DATA_MIN, DATA_MAX, '0, '0, '0, '0};
    send_matrix(SIZE_TWO, m);
    m = '{ONE, 2 * ONE, 3 * ONE, 4 * ONE, 5 * ONE, 6 * ONE, 7 * ONE, 8 * ONE, 10 * ONE};
    send_matrix(SIZE_THREE, m);
    m = '{DATA_MAX, DATA_MIN, DATA_MAX, DATA_MIN, DATA_MAX, DATA_MIN,
          DATA_MAX, DATA_MAX, DATA_MIN};
    send_matrix(SIZE_THREE, m);
    m = '{2 * ONE, ONE, '0, ONE, 2 * ONE, ONE, '0, ONE, 2 * ONE};
    send_matrix(SIZE_THREE, m);
    drain();

    // Random, in three idling phases.
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM / 3) begin
        drain();
        tx_idle_pct = 80;
        rx_idle_pct = 36;
      end else if (i == 2 * N_RANDOM / 3) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      send_random();
    end
    drain();
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("Covered %0d inverses (%0d singular); sizes 0/1/2/3 sent %0d/%0d/%0d/%0d.",
             inv_count, singular_count, size_seen[0], size_seen[1], size_seen[2],
             size_seen[3]);
    if (fail_count == 0 && pending == 0) begin
      $display("small_matrix_inverse_top test passed");
    end else begin
      $display("small_matrix_inverse_top test failed");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/smi_pkg.sv
rtl/small_matrix_inverse_top.sv
rtl/smi_checker.sv
tb/small_matrix_inverse_checker.sv
tb/tb_small_matrix_inverse_top.sv
